FILE: rtl/qar_pkg.sv
package qar_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 31;

    // magnitude line inside the normalizer spans square, sum and the root stages
    localparam int MLINE_LEN   = SQRT_STEPS + 2;
    localparam int NORM_LAT    = 3 + SQRT_STEPS + 1 + DIV_STEPS;
    localparam int CORDIC_LAT  = CORDIC_STEPS;
    localparam int TRIG_DLY    = NORM_LAT - CORDIC_LAT;
    localparam int BACK_STAGES = 7;
    localparam int TOTAL_LAT   = NORM_LAT + BACK_STAGES;
    localparam int CARRY_LEN   = TOTAL_LAT - 1;

    localparam int QDEPTH  = 4;
    localparam int QADDR_W = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic signed [32:0] ANG_PI      = 33'sd843314857;
    localparam logic signed [32:0] ANG_TWO_PI  = 33'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // operand order of the cross products: c[j] = a[XA[j]]*b[XB[j]] - a[XB[j]]*b[XA[j]]
    localparam int XA [3] = '{1, 2, 0};
    localparam int XB [3] = '{2, 0, 1};

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] piv;
        logic [2:0][32:0] d;
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
        logic [4:0]       sh;
        logic [31:0]      z;
        logic             zero;
    } fw_t;

    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][32:0] d;
        logic             zero;
    } carry_t;

    typedef struct packed {
        logic full;
        logic nempty;
    } qstat_t;

    function automatic logic signed [33:0] atan_step(input int i);
        logic signed [33:0] a;
        case (i)
            0:       a = 34'sd843314857;
            1:       a = 34'sd497837829;
            2:       a = 34'sd263043837;
            3:       a = 34'sd133525159;
            4:       a = 34'sd67021687;
            5:       a = 34'sd33543516;
            6:       a = 34'sd16775851;
            7:       a = 34'sd8388437;
            8:       a = 34'sd4194283;
            9:       a = 34'sd2097149;
            default: a = 34'sd1 <<< (30 - i);
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/qar_front.sv
module qar_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] pivot_x,
    input  logic signed [31:0] pivot_y,
    input  logic signed [31:0] pivot_z,
    input  logic signed [31:0] axis_x,
    input  logic signed [31:0] axis_y,
    input  logic signed [31:0] axis_z,
    input  logic signed [31:0] turn_angle,
    input  logic               q_full,
    output logic               push,
    output qar_pkg::fw_t       word
);
    import qar_pkg::*;

    logic              vld_reg;
    logic              vld_next;
    fw_t               word_reg;
    fw_t               word_next;
    logic              accept;
    logic [2:0][31:0]  ax;
    logic [31:0]       mag_or;
    logic signed [32:0] ang_ext;
    logic signed [32:0] ang_wrap;

    // shift that brings the largest magnitude into [2^30, 2^31]
    function automatic logic [4:0] norm_shift(input logic [31:0] m);
        logic [4:0] s;
        s = '0;
        if (!m[31])
        begin
            for (int b = 0; b <= 30; b++)
            begin
                if (m[b])
                begin
                    s = 5'(30 - b);
                end
            end
        end
        return s;
    endfunction

    assign in_stall = vld_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = vld_reg && !q_full;
    assign word     = word_reg;

    always_comb
    begin
        ax             = {axis_z, axis_y, axis_x};
        word_next.pos  = {pos_z, pos_y, pos_x};
        word_next.piv  = {pivot_z, pivot_y, pivot_x};
        for (int i = 0; i < 3; i++)
        begin
            word_next.d[i]   = {word_next.pos[i][31], word_next.pos[i]}
                             - {word_next.piv[i][31], word_next.piv[i]};
            word_next.neg[i] = ax[i][31];
            word_next.mag[i] = ax[i][31] ? 32'd0 - ax[i] : ax[i];
        end
        mag_or         = word_next.mag[0] | word_next.mag[1] | word_next.mag[2];
        word_next.zero = (mag_or == '0);
        word_next.sh   = norm_shift(mag_or);

        ang_ext = {turn_angle[31], turn_angle};
        if (ang_ext > ANG_PI)
        begin
            ang_wrap = ang_ext - ANG_TWO_PI;
        end
        else if (ang_ext < -ANG_PI)
        begin
            ang_wrap = ang_ext + ANG_TWO_PI;
        end
        else
        begin
            ang_wrap = ang_ext;
        end
        // half angle in Q2.30 is the wrapped angle doubled
        word_next.z = {ang_wrap[30:0], 1'b0};
    end

    always_comb
    begin
        if (accept)
        begin
            vld_next = 1'b1;
        end
        else if (push)
        begin
            vld_next = 1'b0;
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= word_next;
        end
    end

endmodule

FILE: rtl/qar_queue.sv
module qar_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  qar_pkg::fw_t    wdata,
    input  logic            pop,
    output qar_pkg::fw_t    rdata,
    output qar_pkg::qstat_t stat
);
    import qar_pkg::*;

    fw_t               mem [QDEPTH];
    logic [QADDR_W-1:0] wptr_reg;
    logic [QADDR_W-1:0] rptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic [QCNT_W-1:0]  cnt_next;

    assign rdata       = mem[rptr_reg];
    assign stat.full   = (cnt_reg == QCNT_W'(QDEPTH));
    assign stat.nempty = (cnt_reg != '0);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg != QCNT_W'(QDEPTH)) || pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("queue read while empty");

endmodule

FILE: rtl/qar_cordic.sv
module qar_cordic (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] z_in,
    output logic signed [31:0] w,
    output logic signed [32:0] sn
);
    import qar_pkg::*;

    logic signed [33:0] x_reg [CORDIC_STEPS];
    logic signed [33:0] y_reg [CORDIC_STEPS];
    logic signed [33:0] z_reg [CORDIC_STEPS];
    logic signed [33:0] xin   [CORDIC_STEPS];
    logic signed [33:0] yin   [CORDIC_STEPS];
    logic signed [33:0] zin   [CORDIC_STEPS];
    logic signed [33:0] x_next [CORDIC_STEPS];
    logic signed [33:0] y_next [CORDIC_STEPS];
    logic signed [33:0] z_next [CORDIC_STEPS];

    always_comb
    begin
        xin[0] = CORDIC_GAIN;
        yin[0] = '0;
        zin[0] = 34'(z_in);
        for (int i = 1; i < CORDIC_STEPS; i++)
        begin
            xin[i] = x_reg[i-1];
            yin[i] = y_reg[i-1];
            zin[i] = z_reg[i-1];
        end
        // one micro-rotation per stage, direction from the residual angle sign
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (!zin[i][33])
            begin
                x_next[i] = xin[i] - (yin[i] >>> i);
                y_next[i] = yin[i] + (xin[i] >>> i);
                z_next[i] = zin[i] - atan_step(i);
            end
            else
            begin
                x_next[i] = xin[i] + (yin[i] >>> i);
                y_next[i] = yin[i] - (xin[i] >>> i);
                z_next[i] = zin[i] + atan_step(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next[i];
            end
        end
    end

    // cos goes to Q4.28 with round half up, sin stays Q2.30
    assign w  = 32'((x_reg[CORDIC_STEPS-1] + 34'sd2) >>> 2);
    assign sn = y_reg[CORDIC_STEPS-1][32:0];

endmodule

FILE: rtl/qar_norm.sv
module qar_norm (
    input  logic             clk,
    input  logic             en,
    input  logic [2:0][31:0] mag,
    input  logic [2:0]       neg,
    input  logic [4:0]       sh,
    output logic [2:0][31:0] n
);
    import qar_pkg::*;

    typedef struct packed {
        logic [2:0][31:0] mag;
        logic [2:0]       neg;
    } mline_t;

    logic [2:0][31:0] ms0_reg;
    logic [2:0]       neg0_reg;
    logic [2:0][63:0] sq_reg;
    logic [63:0]      sum_reg;
    mline_t           mline_reg [MLINE_LEN];

    logic [63:0]      sx_reg  [SQRT_STEPS];
    logic [63:0]      sr_reg  [SQRT_STEPS];
    logic [63:0]      sx_in   [SQRT_STEPS];
    logic [63:0]      sr_in   [SQRT_STEPS];
    logic [63:0]      sx_next [SQRT_STEPS];
    logic [63:0]      sr_next [SQRT_STEPS];
    logic [63:0]      sbit    [SQRT_STEPS];

    logic [2:0][61:0] num_reg;
    logic [31:0]      nlen_reg;
    logic [2:0]       nneg_reg;

    logic [2:0][32:0] rem_reg  [DIV_STEPS];
    logic [2:0][30:0] quo_reg  [DIV_STEPS];
    logic [2:0][30:0] low_reg  [DIV_STEPS];
    logic [31:0]      dlen_reg [DIV_STEPS];
    logic [2:0]       dneg_reg [DIV_STEPS];

    logic [2:0][32:0] rem_in   [DIV_STEPS];
    logic [2:0][30:0] quo_in   [DIV_STEPS];
    logic [2:0][30:0] low_in   [DIV_STEPS];
    logic [31:0]      dlen_in  [DIV_STEPS];
    logic [2:0]       dneg_in  [DIV_STEPS];
    logic [2:0][32:0] trial    [DIV_STEPS];
    logic [2:0]       ge       [DIV_STEPS];
    logic [2:0][32:0] rem_next [DIV_STEPS];

    // integer square root, one result bit per stage
    always_comb
    begin
        sx_in[0] = sum_reg;
        sr_in[0] = '0;
        for (int k = 1; k < SQRT_STEPS; k++)
        begin
            sx_in[k] = sx_reg[k-1];
            sr_in[k] = sr_reg[k-1];
        end
        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            sbit[k] = 64'd1 << (62 - 2 * k);
            if (sx_in[k] >= sr_in[k] + sbit[k])
            begin
                sx_next[k] = sx_in[k] - (sr_in[k] + sbit[k]);
                sr_next[k] = (sr_in[k] >> 1) + sbit[k];
            end
            else
            begin
                sx_next[k] = sx_in[k];
                sr_next[k] = sr_in[k] >> 1;
            end
        end
    end

    // restoring division, quotient bits 30 down to 0
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            rem_in[0][j] = {2'b00, num_reg[j][61:31]};
            low_in[0][j] = num_reg[j][30:0];
            quo_in[0][j] = '0;
        end
        dlen_in[0] = nlen_reg;
        dneg_in[0] = nneg_reg;
        for (int k = 1; k < DIV_STEPS; k++)
        begin
            rem_in[k]  = rem_reg[k-1];
            low_in[k]  = low_reg[k-1];
            quo_in[k]  = quo_reg[k-1];
            dlen_in[k] = dlen_reg[k-1];
            dneg_in[k] = dneg_reg[k-1];
        end
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                trial[k][j] = {rem_in[k][j][31:0], low_in[k][j][30]};
                ge[k][j]    = trial[k][j] >= {1'b0, dlen_in[k]};
                rem_next[k][j] = ge[k][j] ? trial[k][j] - {1'b0, dlen_in[k]} : trial[k][j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ms0_reg[j] <= mag[j] << sh;
                sq_reg[j]  <= ms0_reg[j] * ms0_reg[j];
            end
            neg0_reg <= neg;
            sum_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];

            mline_reg[0] <= {ms0_reg, neg0_reg};
            for (int k = 1; k < MLINE_LEN; k++)
            begin
                mline_reg[k] <= mline_reg[k-1];
            end

            for (int k = 0; k < SQRT_STEPS; k++)
            begin
                sx_reg[k] <= sx_next[k];
                sr_reg[k] <= sr_next[k];
            end

            // numerator carries the half-divisor for round half up
            for (int j = 0; j < 3; j++)
            begin
                num_reg[j] <= {mline_reg[MLINE_LEN-1].mag[j], 30'b0}
                            + 62'(sr_reg[SQRT_STEPS-1][31:1]);
            end
            nlen_reg <= sr_reg[SQRT_STEPS-1][31:0];
            nneg_reg <= mline_reg[MLINE_LEN-1].neg;

            for (int k = 0; k < DIV_STEPS; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    rem_reg[k][j] <= rem_next[k][j];
                    low_reg[k][j] <= {low_in[k][j][29:0], 1'b0};
                    quo_reg[k][j] <= {quo_in[k][j][29:0], ge[k][j]};
                end
                dlen_reg[k] <= dlen_in[k];
                dneg_reg[k] <= dneg_in[k];
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            n[j] = dneg_reg[DIV_STEPS-1][j] ? 32'd0 - {1'b0, quo_reg[DIV_STEPS-1][j]}
                                            : {1'b0, quo_reg[DIV_STEPS-1][j]};
        end
    end

endmodule

FILE: rtl/quaternion_axis_rotate_unit.sv
// Rotates a Q16.16 point about an axis through a pivot by a Q4.28 angle.
// Input channel: in_valid / in_stall with the point, pivot, axis and angle
// as separate ports; a word is taken at a rising edge with in_valid high
// and in_stall low. Output channel: out_valid / out_stall with rot_x,
// rot_y, rot_z and zero_axis, taken the same way.
// A front register classifies each word (pivot offset, axis magnitudes,
// normalize shift, angle wrap, zero-axis test) and hands it to a four-word
// queue. The back end is a 74-stage pipeline: a 30-step CORDIC for the
// half-angle sine and cosine runs beside the axis normalizer (square root,
// 32 stages, then three 31-stage dividers), followed by seven stages of
// products, rounding and saturation.
// Throughput is one word per cycle while the output is not stalled.
// A zero axis returns the point unchanged with zero_axis set.
// When out_stall holds a valid output, the whole back pipeline freezes
// and the output holds; the queue then fills and in_stall rises once the
// front register holds a word it cannot pass on. Reset empties the front
// register, queue and all pipeline valid bits; no word is lost or invented.
module quaternion_axis_rotate_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] pivot_x,
    input  logic signed [31:0] pivot_y,
    input  logic signed [31:0] pivot_z,
    input  logic signed [31:0] axis_x,
    input  logic signed [31:0] axis_y,
    input  logic signed [31:0] axis_z,
    input  logic signed [31:0] turn_angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] rot_x,
    output logic signed [31:0] rot_y,
    output logic signed [31:0] rot_z,
    output logic               zero_axis
);
    import qar_pkg::*;

    typedef struct packed {
        logic [31:0] w;
        logic [32:0] sn;
    } trig_t;

    fw_t              f_word;
    logic             f_push;
    qstat_t           q_stat;
    fw_t              q_head;
    logic             q_pop;
    logic             adv;

    logic signed [31:0] c_w;
    logic signed [32:0] c_sn;
    logic [2:0][31:0]   n_vec;

    logic [TOTAL_LAT-1:0] vld_reg;
    carry_t               carry_reg [CARRY_LEN];
    trig_t                trig_reg  [TRIG_DLY];

    logic signed [64:0] pu_reg   [3];
    logic signed [31:0] u_reg    [3];
    logic signed [31:0] u69_reg  [3];
    logic signed [31:0] u70_reg  [3];
    logic signed [64:0] du_reg   [6];
    logic signed [36:0] t_reg    [3];
    logic signed [68:0] wtp_reg  [3];
    logic signed [68:0] tu_reg   [6];
    logic signed [41:0] wt_reg   [3];
    logic signed [41:0] r_reg    [3];
    logic signed [31:0] w67_reg;
    logic signed [31:0] w68_reg;
    logic signed [31:0] w69_reg;
    logic signed [31:0] w70_reg;
    logic signed [31:0] rot_reg  [3];
    logic               zero_reg;

    logic signed [65:0] tdiff [3];
    logic signed [69:0] rdiff [3];
    logic signed [43:0] acc   [3];
    logic signed [31:0] sat   [3];

    qar_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .pivot_x    (pivot_x),
        .pivot_y    (pivot_y),
        .pivot_z    (pivot_z),
        .axis_x     (axis_x),
        .axis_y     (axis_y),
        .axis_z     (axis_z),
        .turn_angle (turn_angle),
        .q_full     (q_stat.full),
        .push       (f_push),
        .word       (f_word)
    );

    qar_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata (f_word),
        .pop   (q_pop),
        .rdata (q_head),
        .stat  (q_stat)
    );

    // back pipeline moves as one whenever the output register can take a word
    assign adv   = !vld_reg[TOTAL_LAT-1] || !out_stall;
    assign q_pop = adv && q_stat.nempty;

    qar_cordic u_cordic (
        .clk  (clk),
        .en   (adv),
        .z_in (q_head.z),
        .w    (c_w),
        .sn   (c_sn)
    );

    qar_norm u_norm (
        .clk (clk),
        .en  (adv),
        .mag (q_head.mag),
        .neg (q_head.neg),
        .sh  (q_head.sh),
        .n   (n_vec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], q_pop};
        end
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            tdiff[j] = 66'(du_reg[2*j]) - 66'(du_reg[2*j+1]);
            rdiff[j] = 70'(tu_reg[2*j]) - 70'(tu_reg[2*j+1]);
            acc[j]   = 44'($signed(carry_reg[CARRY_LEN-1].pos[j])) + 44'(wt_reg[j])
                     + 44'(r_reg[j]);
            if (acc[j] > 44'sd2147483647)
            begin
                sat[j] = 32'sh7fffffff;
            end
            else if (acc[j] < -44'sd2147483648)
            begin
                sat[j] = 32'sh80000000;
            end
            else
            begin
                sat[j] = acc[j][31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            carry_reg[0] <= {q_head.pos, q_head.d, q_head.zero};
            for (int k = 1; k < CARRY_LEN; k++)
            begin
                carry_reg[k] <= carry_reg[k-1];
            end

            // line up sine and cosine with the normalized axis
            trig_reg[0] <= {c_w, c_sn};
            for (int k = 1; k < TRIG_DLY; k++)
            begin
                trig_reg[k] <= trig_reg[k-1];
            end

            w67_reg <= trig_reg[TRIG_DLY-1].w;
            w68_reg <= w67_reg;
            w69_reg <= w68_reg;
            w70_reg <= w69_reg;

            for (int j = 0; j < 3; j++)
            begin
                pu_reg[j]  <= $signed(n_vec[j]) * $signed(trig_reg[TRIG_DLY-1].sn);
                u_reg[j]   <= 32'((pu_reg[j] + (65'sd1 <<< 31)) >>> 32);
                u69_reg[j] <= u_reg[j];
                u70_reg[j] <= u69_reg[j];

                du_reg[2*j]   <= $signed(carry_reg[NORM_LAT+1].d[XA[j]]) * u_reg[XB[j]];
                du_reg[2*j+1] <= $signed(carry_reg[NORM_LAT+1].d[XB[j]]) * u_reg[XA[j]];

                t_reg[j] <= 37'((tdiff[j] + (66'sd1 <<< 26)) >>> 27);

                wtp_reg[j]    <= w70_reg * t_reg[j];
                tu_reg[2*j]   <= t_reg[XA[j]] * u70_reg[XB[j]];
                tu_reg[2*j+1] <= t_reg[XB[j]] * u70_reg[XA[j]];

                wt_reg[j] <= 42'((wtp_reg[j] + (69'sd1 <<< 27)) >>> 28);
                r_reg[j]  <= 42'((rdiff[j] + (70'sd1 <<< 27)) >>> 28);

                // zero axis passes the point through untouched
                rot_reg[j] <= carry_reg[CARRY_LEN-1].zero
                            ? $signed(carry_reg[CARRY_LEN-1].pos[j]) : sat[j];
            end
            zero_reg <= carry_reg[CARRY_LEN-1].zero;
        end
    end

    assign out_valid = vld_reg[TOTAL_LAT-1];
    assign rot_x     = rot_reg[0];
    assign rot_y     = rot_reg[1];
    assign rot_z     = rot_reg[2];
    assign zero_axis = zero_reg;

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");

    a_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> vld_reg[0] == $past(q_stat.nempty))
        else $error("queue pop and first stage disagree");

    a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> vld_reg[TOTAL_LAT-1] == $past(vld_reg[TOTAL_LAT-2]))
        else $error("output valid lost or invented");

endmodule
